// ===== sv/cddn_pkg.sv =====
// ----------------------------------------------------------------------------
// Civil date / day number package
// Shared types, calendar constants and reciprocal constants for the
// constant divisions of the date conversion pipeline.
// ----------------------------------------------------------------------------
package cddn_pkg;

	localparam int EPOCH_SHIFT  = 719468;
	localparam int DAYS_PER_ERA = 146097;
	localparam int DN_MIN       = -134774;
	localparam int DN_MAX       = 2932896;
	localparam int YEAR_MIN     = 1601;
	localparam int YEAR_MAX     = 9999;

	// Bias that makes the day number nonnegative while keeping it congruent to
	// the day number plus four modulo seven.
	localparam int WD_BIAS = 4 + 7 * ((-DN_MIN + 6) / 7);

	// Floor division by a constant D for x below 2**N is (x * M) >> SH with
	// M = 2**SH / D + 1, exact as long as 2**N * D <= 2**SH.
	localparam int DIV100_SH = 21;
	localparam logic [14:0] DIV100_M = 15'((64'd1 << DIV100_SH) / 64'd100 + 64'd1);
	localparam int DIV7_SH = 25;
	localparam logic [22:0] DIV7_M = 23'((64'd1 << DIV7_SH) / 64'd7 + 64'd1);
	localparam int ERA_SH = 40;
	localparam logic [22:0] ERA_M = 23'((64'd1 << ERA_SH) / 64'd146097 + 64'd1);
	localparam int DIV1460_SH = 29;
	localparam logic [18:0] DIV1460_M = 19'((64'd1 << DIV1460_SH) / 64'd1460 + 64'd1);
	localparam int DIV36524_SH = 34;
	localparam logic [18:0] DIV36524_M = 19'((64'd1 << DIV36524_SH) / 64'd36524 + 64'd1);
	localparam int DIV146096_SH = 36;
	localparam logic [18:0] DIV146096_M =
		19'((64'd1 << DIV146096_SH) / 64'd146096 + 64'd1);
	localparam int DIV365_SH = 27;
	localparam logic [18:0] DIV365_M = 19'((64'd1 << DIV365_SH) / 64'd365 + 64'd1);
	localparam int DIV153_SH = 19;
	localparam logic [11:0] DIV153_M = 12'((64'd1 << DIV153_SH) / 64'd153 + 64'd1);

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [8:0]  ordinal;
	} date_t;

	// First day of each month within a year that starts on March 1.
	function automatic logic [8:0] march_offset(input logic [3:0] mp);
		logic [8:0] ofs;
		case (mp)
			4'd0: ofs = 9'd0;
			4'd1: ofs = 9'd31;
			4'd2: ofs = 9'd61;
			4'd3: ofs = 9'd92;
			4'd4: ofs = 9'd122;
			4'd5: ofs = 9'd153;
			4'd6: ofs = 9'd184;
			4'd7: ofs = 9'd214;
			4'd8: ofs = 9'd245;
			4'd9: ofs = 9'd275;
			4'd10: ofs = 9'd306;
			4'd11: ofs = 9'd337;
			default: ofs = 9'd0;
		endcase
		return ofs;
	endfunction

endpackage

// ===== sv/cddn_from_days.sv =====
// ----------------------------------------------------------------------------
// Day number to civil date
// Ten-stage pipeline that splits a day number into 400-year era, year of
// era, day of year and month, and also gives the day's ordinal in its year.
// ----------------------------------------------------------------------------
module cddn_from_days (
	input  logic                 clk,
	input  logic signed [22:0]   z,
	output cddn_pkg::date_t      date
);

	logic signed [23:0] s_full;
	logic [21:0] s_s1, s_s2;
	logic [44:0] ep_s2;
	logic [4:0]  era_w;
	logic [4:0]  era_s3, era_s4, era_s5, era_s6, era_s7, era_s8, era_s9;
	logic [17:0] doe_s3, doe_s4, doe_s5, doe_s6, doe_s7;
	logic [36:0] p1_s4, p2_s4, p3_s4;
	logic [17:0] t_s5;
	logic [36:0] py_s6;
	logic [8:0]  yoe_w, yoe_s7, yoe_s8, yoe_s9;
	logic [23:0] ph_s7;
	logic [8:0]  doy_s8, doy_s9;
	logic [22:0] pm_s9;
	logic [3:0]  mp_w;
	logic        jan_feb;
	logic        leap;
	cddn_pkg::date_t date_w, date_s10;

	assign s_full = 24'(z) + 24'(cddn_pkg::EPOCH_SHIFT);
	assign era_w  = 5'(ep_s2 >> cddn_pkg::ERA_SH);
	assign yoe_w  = 9'(py_s6 >> cddn_pkg::DIV365_SH);
	assign mp_w   = 4'(pm_s9 >> cddn_pkg::DIV153_SH);
	assign jan_feb = (mp_w >= 4'd10);
	// Within an era the year of era carries the leap rule of the civil year
	// that holds the following months of March through December.
	assign leap = (yoe_s9[1:0] == 2'd0) && (yoe_s9 != 9'd100) && (yoe_s9 != 9'd200)
		&& (yoe_s9 != 9'd300);

	always_comb begin
		date_w.day   = 5'(doy_s9 - cddn_pkg::march_offset(mp_w) + 9'd1);
		date_w.month = jan_feb ? (mp_w - 4'd9) : (mp_w + 4'd3);
		date_w.year  = 14'(14'(era_s9) * 14'd400) + 14'(yoe_s9) + 14'(jan_feb);
		date_w.ordinal = jan_feb ? (doy_s9 - 9'd306) : (doy_s9 + 9'd59 + 9'(leap));
	end

	always_ff @(posedge clk) begin
		s_s1 <= s_full[21:0];

		ep_s2 <= 45'(s_s1) * 45'(cddn_pkg::ERA_M);
		s_s2  <= s_s1;

		era_s3 <= era_w;
		doe_s3 <= 18'(s_s2 - 22'(22'(era_w) * 22'(cddn_pkg::DAYS_PER_ERA)));

		p1_s4  <= 37'(doe_s3) * 37'(cddn_pkg::DIV1460_M);
		p2_s4  <= 37'(doe_s3) * 37'(cddn_pkg::DIV36524_M);
		p3_s4  <= 37'(doe_s3) * 37'(cddn_pkg::DIV146096_M);
		doe_s4 <= doe_s3;
		era_s4 <= era_s3;

		t_s5 <= doe_s4 - 18'(p1_s4 >> cddn_pkg::DIV1460_SH)
			+ 18'(p2_s4 >> cddn_pkg::DIV36524_SH)
			- 18'(p3_s4 >> cddn_pkg::DIV146096_SH);
		doe_s5 <= doe_s4;
		era_s5 <= era_s4;

		py_s6  <= 37'(t_s5) * 37'(cddn_pkg::DIV365_M);
		doe_s6 <= doe_s5;
		era_s6 <= era_s5;

		yoe_s7 <= yoe_w;
		ph_s7  <= 24'(yoe_w) * 24'(cddn_pkg::DIV100_M);
		doe_s7 <= doe_s6;
		era_s7 <= era_s6;

		doy_s8 <= 9'(doe_s7 - (18'(yoe_s7) * 18'd365 + 18'(yoe_s7 >> 2)
			- 18'(ph_s7 >> cddn_pkg::DIV100_SH)));
		yoe_s8 <= yoe_s7;
		era_s8 <= era_s7;

		pm_s9  <= (23'(doy_s8) * 23'd5 + 23'd2) * 23'(cddn_pkg::DIV153_M);
		doy_s9 <= doy_s8;
		yoe_s9 <= yoe_s8;
		era_s9 <= era_s8;

		date_s10 <= date_w;
	end

	assign date = date_s10;

endmodule

// ===== sv/civil_date_day_number_convert_top.sv =====
// ----------------------------------------------------------------------------
// Civil date / day number converter
// Converts between proleptic Gregorian dates and day numbers counted from
// 1970-01-01, and gives the weekday and ISO 8601 week of the result.
// ----------------------------------------------------------------------------
// A word is taken at a rising edge where start is high and busy is low. busy
// is always low, so a new word may be issued in every cycle. mode selects the
// direction: 0 reads year, month and day, 1 reads day_number; the other
// fields are ignored. Out-of-range years, months and day numbers saturate.
// Each word gives one result word: done is high for exactly one cycle while
// the result ports carry it, and the result is taken at the edge that ends
// that cycle. The receiver cannot stall the block.
// Throughput is one word per cycle. The depth is set by the constant-reciprocal
// multipliers of the day-to-date pipeline and by the week calculation that
// needs the weekday first.
// The asynchronous reset clears the valid chain only; results that were in
// flight are dropped and done stays low until new words arrive.
// ----------------------------------------------------------------------------
module civil_date_day_number_convert_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [13:0]         year,
	input  logic [3:0]          month,
	input  logic [4:0]          day,
	input  logic signed [22:0]  day_number,
	output logic                done,
	output logic signed [22:0]  result_day_number,
	output logic [13:0]         result_year,
	output logic [3:0]          result_month,
	output logic [4:0]          result_day,
	output logic [2:0]          weekday,
	output logic [5:0]          iso_week
);

	localparam int LAT = 19;
	localparam int DLY = 11;

	logic [LAT-1:0] vld_q;

	logic               mode_s1, mode_s2, mode_s3;
	logic [13:0]        year_s1;
	logic [3:0]         month_s1;
	logic [4:0]         day_s1;
	logic signed [22:0] dn_in_s1;

	logic [13:0]        y_c;
	logic [3:0]         m_c;
	logic               m_low;
	logic [3:0]         mp_w;
	logic signed [22:0] dn1_w;
	logic [13:0]        yy_s2, yy_s3;
	logic signed [9:0]  doy_s2, doy_s3;
	logic signed [22:0] dn1_s2, dn1_s3;

	logic [28:0]        p100_s3;
	logic [26:0]        p400_s3;
	logic [23:0]        pos_w;
	logic signed [24:0] dn_raw;
	logic signed [22:0] dn0_w;
	logic signed [22:0] dn_s4, dn_s5, dn_s6, dn_s7;

	logic signed [23:0] v_full;
	logic [21:0]        v_s5, v_s6;
	logic [44:0]        wp_s6;
	logic [19:0]        q7_w;
	logic [21:0]        rem_w;
	logic [2:0]         wd_w;
	logic [2:0]         iso_wd_w;
	logic [2:0]         wd_s7;
	logic signed [22:0] thu_s7;

	logic signed [22:0] dn_dly_q [DLY];
	logic [2:0]         wd_dly_q [DLY];

	cddn_pkg::date_t    date_dn, date_thu, date_s18;
	logic [31:0]        wk_p_s18;

	logic signed [22:0] dn_s19;
	cddn_pkg::date_t    date_s19;
	logic [2:0]         wd_s19;
	logic [5:0]         week_s19;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LAT-1];

	// Saturation of the year, month and day number fields and month lookup.
	always_comb begin
		if (year_s1 < 14'(cddn_pkg::YEAR_MIN)) begin
			y_c = 14'(cddn_pkg::YEAR_MIN);
		end else if (year_s1 > 14'(cddn_pkg::YEAR_MAX)) begin
			y_c = 14'(cddn_pkg::YEAR_MAX);
		end else begin
			y_c = year_s1;
		end
		if (month_s1 == 4'd0) begin
			m_c = 4'd1;
		end else if (month_s1 > 4'd12) begin
			m_c = 4'd12;
		end else begin
			m_c = month_s1;
		end
		m_low = (m_c <= 4'd2);
		mp_w  = m_low ? (m_c + 4'd9) : (m_c - 4'd3);
		if (dn_in_s1 < 23'(cddn_pkg::DN_MIN)) begin
			dn1_w = 23'(cddn_pkg::DN_MIN);
		end else if (dn_in_s1 > 23'(cddn_pkg::DN_MAX)) begin
			dn1_w = 23'(cddn_pkg::DN_MAX);
		end else begin
			dn1_w = dn_in_s1;
		end
	end

	// Day number from the March-based year: 365 days a year plus leap days.
	always_comb begin
		pos_w = 24'(yy_s3) * 24'd365 + 24'(yy_s3 >> 2)
			+ 24'(p400_s3 >> cddn_pkg::DIV100_SH);
		dn_raw = $signed({1'b0, pos_w}) - $signed(25'(p100_s3 >> cddn_pkg::DIV100_SH))
			+ 25'(doy_s3) - 25'(cddn_pkg::EPOCH_SHIFT);
		if (dn_raw < 25'(cddn_pkg::DN_MIN)) begin
			dn0_w = 23'(cddn_pkg::DN_MIN);
		end else if (dn_raw > 25'(cddn_pkg::DN_MAX)) begin
			dn0_w = 23'(cddn_pkg::DN_MAX);
		end else begin
			dn0_w = dn_raw[22:0];
		end
	end

	assign v_full   = 24'(dn_s4) + 24'(cddn_pkg::WD_BIAS);
	assign q7_w     = 20'(wp_s6 >> cddn_pkg::DIV7_SH);
	assign rem_w    = v_s6 - 22'(22'(q7_w) * 22'd7);
	assign wd_w     = rem_w[2:0];
	assign iso_wd_w = (wd_w == 3'd0) ? 3'd7 : wd_w;

	always_ff @(posedge clk) begin
		mode_s1  <= mode;
		year_s1  <= year;
		month_s1 <= month;
		day_s1   <= day;
		dn_in_s1 <= day_number;

		mode_s2 <= mode_s1;
		yy_s2   <= y_c - 14'(m_low);
		doy_s2  <= $signed({1'b0, cddn_pkg::march_offset(mp_w)}) + $signed({5'b0, day_s1})
			- 10'sd1;
		dn1_s2  <= dn1_w;

		mode_s3 <= mode_s2;
		yy_s3   <= yy_s2;
		doy_s3  <= doy_s2;
		dn1_s3  <= dn1_s2;
		p100_s3 <= 29'(yy_s2) * 29'(cddn_pkg::DIV100_M);
		p400_s3 <= 27'(yy_s2 >> 2) * 27'(cddn_pkg::DIV100_M);

		dn_s4 <= mode_s3 ? dn1_s3 : dn0_w;

		v_s5  <= v_full[21:0];
		dn_s5 <= dn_s4;

		wp_s6 <= 45'(v_s5) * 45'(cddn_pkg::DIV7_M);
		v_s6  <= v_s5;
		dn_s6 <= dn_s5;

		wd_s7  <= wd_w;
		dn_s7  <= dn_s6;
		thu_s7 <= dn_s6 - 23'(iso_wd_w) + 23'sd4;

		dn_dly_q[0] <= dn_s7;
		wd_dly_q[0] <= wd_s7;
		for (int i = 1; i < DLY; i++) begin
			dn_dly_q[i] <= dn_dly_q[i-1];
			wd_dly_q[i] <= wd_dly_q[i-1];
		end

		date_s18 <= date_dn;
		wk_p_s18 <= 32'(date_thu.ordinal) * 32'(cddn_pkg::DIV7_M);

		dn_s19   <= dn_dly_q[DLY-1];
		wd_s19   <= wd_dly_q[DLY-1];
		date_s19 <= date_s18;
		week_s19 <= 6'(wk_p_s18 >> cddn_pkg::DIV7_SH) + 6'd1;
	end

	cddn_from_days u_date (
		.clk  (clk),
		.z    (dn_s7),
		.date (date_dn)
	);

	cddn_from_days u_thu (
		.clk  (clk),
		.z    (thu_s7),
		.date (date_thu)
	);

	assign result_day_number = dn_s19;
	assign result_year       = date_s19.year;
	assign result_month      = date_s19.month;
	assign result_day        = date_s19.day;
	assign weekday           = wd_s19;
	assign iso_week          = week_s19;

endmodule

// ===== verif/cddn_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Civil date converter verification package
// Codes shared by the stimulus and the checker of the date converter bench.
// ----------------------------------------------------------------------------
package cddn_tb_pkg;

	typedef enum logic {
		MODE_TO_DAYS = 1'b0,
		MODE_TO_DATE = 1'b1
	} convert_mode_t;

endpackage

// ===== verif/civil_date_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Civil date converter checker
// Watches the word and result ports of the converter, computes the expected
// day number, normalized date, weekday and ISO week of every accepted word,
// and compares each result word in order against the oldest expected one.
// ----------------------------------------------------------------------------
module civil_date_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               mode,
	input  logic [13:0]        year,
	input  logic [3:0]         month,
	input  logic [4:0]         day,
	input  logic signed [22:0] day_number,
	input  logic               done,
	input  logic signed [22:0] result_day_number,
	input  logic [13:0]        result_year,
	input  logic [3:0]         result_month,
	input  logic [4:0]         result_day,
	input  logic [2:0]         weekday,
	input  logic [5:0]         iso_week,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic signed [22:0] day_number;
		logic [13:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [2:0]         weekday;
		logic [5:0]         iso_week;
	} civil_result_t;

	civil_result_t expected_dates[$];

	function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Year counted from March so that the leap day falls at the end.
	function automatic longint days_since_epoch(input longint y, input longint m,
		input longint d);
		longint shifted_year;
		longint era;
		longint year_of_era;
		longint march_month;
		longint day_of_year;
		longint day_of_era;
		shifted_year = (m <= 2) ? y - 1 : y;
		era = shifted_year / 400;
		year_of_era = shifted_year - era * 400;
		march_month = (m > 2) ? m - 3 : m + 9;
		day_of_year = (153 * march_month + 2) / 5 + d - 1;
		day_of_era = year_of_era * 365 + year_of_era / 4 - year_of_era / 100 + day_of_year;
		return era * cddn_pkg::DAYS_PER_ERA + day_of_era - cddn_pkg::EPOCH_SHIFT;
	endfunction

	function automatic void civil_from_days(input longint dn, output longint y,
		output longint m, output longint d);
		longint shifted;
		longint era;
		longint day_of_era;
		longint year_of_era;
		longint day_of_year;
		longint march_month;
		shifted = dn + cddn_pkg::EPOCH_SHIFT;
		if (shifted < 0)
			shifted = 0;
		era = shifted / cddn_pkg::DAYS_PER_ERA;
		day_of_era = shifted - era * cddn_pkg::DAYS_PER_ERA;
		year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
			- day_of_era / 146096) / 365;
		day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
		march_month = (5 * day_of_year + 2) / 153;
		m = (march_month < 10) ? march_month + 3 : march_month - 9;
		d = day_of_year - (153 * march_month + 2) / 5 + 1;
		y = year_of_era + era * 400 + ((m <= 2) ? 1 : 0);
	endfunction

	function automatic civil_result_t convert_civil_date(input cddn_tb_pkg::convert_mode_t op,
		input logic [13:0] y_in, input logic [3:0] m_in, input logic [4:0] d_in,
		input logic signed [22:0] dn_in);
		civil_result_t r;
		longint dn;
		longint y;
		longint m;
		longint d;
		longint wd;
		longint iso_wd;
		longint thursday;
		longint thu_year;
		longint thu_month;
		longint thu_day;
		longint week;
		if (op == cddn_tb_pkg::MODE_TO_DAYS)
			dn = days_since_epoch(
				clamp_range(longint'(y_in), cddn_pkg::YEAR_MIN, cddn_pkg::YEAR_MAX),
				clamp_range(longint'(m_in), 1, 12), longint'(d_in));
		else
			dn = longint'(dn_in);
		dn = clamp_range(dn, cddn_pkg::DN_MIN, cddn_pkg::DN_MAX);
		civil_from_days(dn, y, m, d);
		wd = ((dn + 4) % 7 + 7) % 7;
		iso_wd = (wd == 0) ? 7 : wd;
		thursday = dn - iso_wd + 4;
		civil_from_days(thursday, thu_year, thu_month, thu_day);
		week = clamp_range((thursday - days_since_epoch(thu_year, 1, 1)) / 7 + 1, 1, 53);
		r.day_number = 23'(dn);
		r.year = 14'(y);
		r.month = 4'(m);
		r.day = 5'(d);
		r.weekday = 3'(wd);
		r.iso_week = 6'(week);
		return r;
	endfunction

	always @(posedge clk) begin
		civil_result_t seen;
		civil_result_t want;
		if (!arst_n) begin
			errors = 0;
			pending = 0;
			expected_dates.delete();
		end else begin
			if (done) begin
				seen = {result_day_number, result_year, result_month, result_day,
					weekday, iso_week};
				if (expected_dates.size() == 0) begin
					errors = errors + 1;
					if (errors <= 10)
						$display("%0t: result word with no word outstanding: dn=%0d %0d-%0d-%0d",
							$time, seen.day_number, seen.year, seen.month, seen.day);
				end else begin
					want = expected_dates.pop_front();
					if (seen.day_number !== want.day_number || seen.year !== want.year
						|| seen.month !== want.month || seen.day !== want.day
						|| seen.weekday !== want.weekday || seen.iso_week !== want.iso_week) begin
						errors = errors + 1;
						if (errors <= 10) begin
							$display("%0t: mismatch: expected dn=%0d %0d-%0d-%0d wd=%0d wk=%0d",
								$time, want.day_number, want.year, want.month, want.day,
								want.weekday, want.iso_week);
							$display("%0t: mismatch: got      dn=%0d %0d-%0d-%0d wd=%0d wk=%0d",
								$time, seen.day_number, seen.year, seen.month, seen.day,
								seen.weekday, seen.iso_week);
						end
					end
				end
			end
			if (start && !busy)
				expected_dates = {expected_dates,
					convert_civil_date(cddn_tb_pkg::convert_mode_t'(mode), year, month,
					day, day_number)};
			pending = expected_dates.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Civil date converter testbench
// Drives directed boundary dates and day numbers, then random words in
// phases with and without sender gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

	localparam int STALL_LIMIT = 2000;
	localparam int WORDS_PER_PHASE = 256;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               mode;
	logic [13:0]        year;
	logic [3:0]         month;
	logic [4:0]         day;
	logic signed [22:0] day_number;
	logic               done;
	logic signed [22:0] result_day_number;
	logic [13:0]        result_year;
	logic [3:0]         result_month;
	logic [4:0]         result_day;
	logic [2:0]         weekday;
	logic [5:0]         iso_week;
	int                 errors;
	int                 pending;
	int                 idle_pct;
	int                 stall_cycles;

	civil_date_day_number_convert_top i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.mode              (mode),
		.year              (year),
		.month             (month),
		.day               (day),
		.day_number        (day_number),
		.done              (done),
		.result_day_number (result_day_number),
		.result_year       (result_year),
		.result_month      (result_month),
		.result_day        (result_day),
		.weekday           (weekday),
		.iso_week          (iso_week)
	);

	civil_date_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.mode              (mode),
		.year              (year),
		.month             (month),
		.day               (day),
		.day_number        (day_number),
		.done              (done),
		.result_day_number (result_day_number),
		.result_year       (result_year),
		.result_month      (result_month),
		.result_day        (result_day),
		.weekday           (weekday),
		.iso_week          (iso_week),
		.errors            (errors),
		.pending           (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("civil_date_day_number_convert_top regression: fail");
			$finish;
		end
	end

	task automatic send_word(input cddn_tb_pkg::convert_mode_t op, input logic [13:0] y,
		input logic [3:0] m, input logic [4:0] d, input logic signed [22:0] dn);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode <= op;
		year <= y;
		month <= m;
		day <= d;
		day_number <= dn;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic send_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d);
		send_word(cddn_tb_pkg::MODE_TO_DAYS, y, m, d, 23'($urandom));
	endtask

	task automatic send_days(input int dn);
		send_word(cddn_tb_pkg::MODE_TO_DATE, 14'($urandom), 4'($urandom), 5'($urandom),
			23'(dn));
	endtask

	task automatic send_random_word();
		int pick;
		logic [13:0] y;
		logic [3:0] m;
		logic [4:0] d;
		logic signed [22:0] dn;
		pick = $urandom_range(99);
		y = ($urandom_range(99) < 85)
			? 14'($urandom_range(cddn_pkg::YEAR_MAX, cddn_pkg::YEAR_MIN)) : 14'($urandom);
		m = ($urandom_range(99) < 90) ? 4'($urandom_range(12, 1)) : 4'($urandom);
		d = ($urandom_range(99) < 90) ? 5'($urandom_range(31, 1)) : 5'($urandom);
		if ($urandom_range(99) < 85)
			dn = 23'(int'($urandom_range(cddn_pkg::DN_MAX - cddn_pkg::DN_MIN))
				+ cddn_pkg::DN_MIN);
		else
			dn = 23'($urandom);
		if (pick < 12) begin
			// Around the turn of the year, where the ISO week changes year.
			if ($urandom_range(1) == 1) begin
				m = 4'd12;
				d = 5'($urandom_range(31, 22));
			end else begin
				m = 4'd1;
				d = 5'($urandom_range(7, 0));
			end
			send_word(cddn_tb_pkg::MODE_TO_DAYS, y, m, d, dn);
		end else if (pick < 56) begin
			send_word(cddn_tb_pkg::MODE_TO_DAYS, y, m, d, dn);
		end else begin
			send_word(cddn_tb_pkg::MODE_TO_DATE, y, m, d, dn);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = cddn_tb_pkg::MODE_TO_DAYS;
		year = '0;
		month = '0;
		day = '0;
		day_number = '0;
		idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_date(14'd1601, 4'd1, 5'd1);
		send_date(14'd9999, 4'd12, 5'd31);
		send_date(14'd0, 4'd0, 5'd0);
		send_date(14'h3FFF, 4'd15, 5'd31);
		send_date(14'd10000, 4'd13, 5'd15);
		send_date(14'd1600, 4'd12, 5'd31);
		send_date(14'd2000, 4'd2, 5'd29);
		send_date(14'd1900, 4'd2, 5'd29);
		send_date(14'd2023, 4'd3, 5'd0);
		send_date(14'd1601, 4'd1, 5'd0);
		send_date(14'd9999, 4'd11, 5'd31);
		send_date(14'd1970, 4'd1, 5'd1);
		send_date(14'd2020, 4'd12, 5'd31);
		send_date(14'd2021, 4'd1, 5'd3);
		send_date(14'd2024, 4'd12, 5'd30);
		send_date(14'd2005, 4'd1, 5'd1);
		send_days(cddn_pkg::DN_MIN);
		send_days(cddn_pkg::DN_MAX);
		send_days(cddn_pkg::DN_MIN - 1);
		send_days(cddn_pkg::DN_MAX + 1);
		send_days(-4194304);
		send_days(4194303);
		send_days(0);
		send_days(-1);
		drain_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: idle_pct = 0;
				1: idle_pct = 54;
				2: idle_pct = 0;
				default: idle_pct = 14;
			endcase
			for (int n = 0; n < WORDS_PER_PHASE; n++)
				send_random_word();
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("civil_date_day_number_convert_top regression: pass");
		else
			$display("civil_date_day_number_convert_top regression: fail");
		$finish;
	end

endmodule

// ===== civil_date_day_number_convert_top.f =====
sv/cddn_pkg.sv
sv/cddn_from_days.sv
sv/civil_date_day_number_convert_top.sv
verif/cddn_tb_pkg.sv
verif/civil_date_checker.sv
verif/tb.sv
